FILE: hdl/bspl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_pkg
// Shared types and constants of the BSP point leaf locator: field widths,
// stream packing, node entry layout and walk controller states.
// ----------------------------------------------------------------------------
package bspl_pkg;

	localparam int NODE_COUNT_DEF = 4096;

	localparam int NODE_IDX_W = 12;
	localparam int NRM_W      = 16;
	localparam int OFF_W      = 31;
	localparam int CHILD_W    = 13;
	localparam int PT_W       = 17;

	// product of one normal component and one coordinate
	localparam int PROD_W = NRM_W + PT_W;
	// three products plus offset, with headroom
	localparam int SIDE_W = PROD_W + 3;

	// slave tdata: node_index, normal_x/y/z, plane_offset, child_front,
	// child_back, point_x/y/z, from the lowest bit up
	localparam int S_IDX_LO = 0;
	localparam int S_NX_LO  = S_IDX_LO + NODE_IDX_W;
	localparam int S_NY_LO  = S_NX_LO + NRM_W;
	localparam int S_NZ_LO  = S_NY_LO + NRM_W;
	localparam int S_OFF_LO = S_NZ_LO + NRM_W;
	localparam int S_CF_LO  = S_OFF_LO + OFF_W;
	localparam int S_CB_LO  = S_CF_LO + CHILD_W;
	localparam int S_PX_LO  = S_CB_LO + CHILD_W;
	localparam int S_PY_LO  = S_PX_LO + PT_W;
	localparam int S_PZ_LO  = S_PY_LO + PT_W;
	localparam int S_TDATA_W = S_PZ_LO + PT_W;
	localparam int M_TDATA_W = 16;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WAIT,
		ST_FIN
	} walk_state_t;

	typedef struct packed {
		logic signed [NRM_W-1:0]   normal_x;
		logic signed [NRM_W-1:0]   normal_y;
		logic signed [NRM_W-1:0]   normal_z;
		logic signed [OFF_W-1:0]   plane_offset;
		logic signed [CHILD_W-1:0] child_front;
		logic signed [CHILD_W-1:0] child_back;
	} node_entry_t;

	typedef struct packed {
		logic signed [PT_W-1:0] x;
		logic signed [PT_W-1:0] y;
		logic signed [PT_W-1:0] z;
	} point_t;

	// side test result of one node, with the children to pick from
	typedef struct packed {
		logic                      vld;
		logic                      neg;
		logic signed [CHILD_W-1:0] child_front;
		logic signed [CHILD_W-1:0] child_back;
	} side_res_t;

endpackage

FILE: hdl/bsp_point_leaf_locator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_point_leaf_locator
// Locates the BSP leaf that holds a query point, walking a node table that
// is loaded through the same input stream.
// ----------------------------------------------------------------------------
// A write beat (tuser 0) stores one node entry; entries at or beyond
// NODE_COUNT are dropped. A query beat (tuser 1) walks from node 0 and
// returns one beat: the leaf index, or tuser 1 with leaf 0 when a child
// names a node beyond the table or the walk visits NODE_COUNT nodes without
// reaching a leaf. A query holds the input until its result is loaded into
// the output register; each node costs one node table read, one multiply
// stage and one add-and-sign stage in a loop. The result waits in an output
// register, so the next beat is taken while it is still unclaimed. Entries
// never written read back as undefined. No clearing pass follows reset.
module bsp_point_leaf_locator #(
	parameter int NODE_COUNT = bspl_pkg::NODE_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// node_index, normal_x, normal_y, normal_z, plane_offset, child_front,
	// child_back, point_x, point_y, point_z
	input  logic [bspl_pkg::S_TDATA_W-1:0]  s_tdata,
	// command
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// leaf_index, zero fill
	output logic [bspl_pkg::M_TDATA_W-1:0]  m_tdata,
	// walk_error
	output logic                             m_tuser
);
	import bspl_pkg::*;

	localparam int MAX_DEPTH = 2 ** NODE_IDX_W;
	localparam int MEM_DEPTH = (NODE_COUNT < MAX_DEPTH) ? NODE_COUNT : MAX_DEPTH;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	cmd_t                  in_cmd;
	logic [NODE_IDX_W-1:0] in_idx;
	node_entry_t           wr_data;
	point_t                in_point;
	logic                  wr_en;
	logic                  rd_en;
	logic [MEM_AW-1:0]     rd_addr;
	node_entry_t           rd_data;
	logic                  rd_vld;
	point_t                point;
	side_res_t             res;
	logic [NODE_IDX_W-1:0] out_leaf;

	assign in_cmd               = cmd_t'(s_tuser);
	assign in_idx               = s_tdata[S_IDX_LO +: NODE_IDX_W];
	assign wr_data.normal_x     = s_tdata[S_NX_LO +: NRM_W];
	assign wr_data.normal_y     = s_tdata[S_NY_LO +: NRM_W];
	assign wr_data.normal_z     = s_tdata[S_NZ_LO +: NRM_W];
	assign wr_data.plane_offset = s_tdata[S_OFF_LO +: OFF_W];
	assign wr_data.child_front  = s_tdata[S_CF_LO +: CHILD_W];
	assign wr_data.child_back   = s_tdata[S_CB_LO +: CHILD_W];
	assign in_point.x           = s_tdata[S_PX_LO +: PT_W];
	assign in_point.y           = s_tdata[S_PY_LO +: PT_W];
	assign in_point.z           = s_tdata[S_PZ_LO +: PT_W];

	// drop writes past the table
	assign wr_en = s_tvalid && s_tready && in_cmd == CMD_WRITE
		&& 32'(in_idx) < 32'(NODE_COUNT);

	bspl_node_mem #(
		.MEM_DEPTH (MEM_DEPTH),
		.MEM_AW    (MEM_AW)
	) u_node_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (in_idx[MEM_AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rd_vld  (rd_vld)
	);

	bspl_side_eval u_side_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.ent_vld (rd_vld),
		.ent     (rd_data),
		.point   (point),
		.res     (res)
	);

	bspl_walk_ctrl #(
		.NODE_COUNT (NODE_COUNT),
		.MEM_DEPTH  (MEM_DEPTH),
		.MEM_AW     (MEM_AW)
	) u_walk_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (s_tvalid),
		.in_rdy   (s_tready),
		.in_cmd   (in_cmd),
		.in_point (in_point),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.res      (res),
		.point    (point),
		.out_vld  (m_tvalid),
		.out_rdy  (m_tready),
		.out_leaf (out_leaf),
		.out_err  (m_tuser)
	);

	assign m_tdata = {{(M_TDATA_W - NODE_IDX_W){1'b0}}, out_leaf};

endmodule

FILE: hdl/bspl_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_node_mem
// Node table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bspl_node_mem #(
	parameter int MEM_DEPTH = 4096,
	parameter int MEM_AW    = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [MEM_AW-1:0]    wr_addr,
	input  bspl_pkg::node_entry_t wr_data,
	input  logic                 rd_en,
	input  logic [MEM_AW-1:0]    rd_addr,
	output bspl_pkg::node_entry_t rd_data,
	output logic                 rd_vld
);
	import bspl_pkg::*;

	node_entry_t mem [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld <= 1'b0;
		end else begin
			rd_vld <= rd_en;
		end
	end

endmodule

FILE: hdl/bspl_side_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_side_eval
// Two-stage side test: normal components times point in stage 1, sum minus
// plane offset and sign in stage 2.
// ----------------------------------------------------------------------------
module bspl_side_eval (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ent_vld,
	input  bspl_pkg::node_entry_t ent,
	input  bspl_pkg::point_t      point,
	output bspl_pkg::side_res_t   res
);
	import bspl_pkg::*;

	logic signed [NRM_W-1:0]   nx, ny, nz;
	logic signed [PT_W-1:0]    px, py, pz;
	logic signed [PROD_W-1:0]  prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [OFF_W-1:0]   off_s1;
	logic signed [CHILD_W-1:0] cf_s1, cb_s1;
	logic                      vld_s1;
	logic signed [SIDE_W-1:0]  side;
	logic                      neg_s2;
	logic signed [CHILD_W-1:0] cf_s2, cb_s2;
	logic                      vld_s2;

	assign nx = ent.normal_x;
	assign ny = ent.normal_y;
	assign nz = ent.normal_z;
	assign px = point.x;
	assign py = point.y;
	assign pz = point.z;

	always_ff @(posedge clk) begin
		prod_x_s1 <= PROD_W'(nx) * PROD_W'(px);
		prod_y_s1 <= PROD_W'(ny) * PROD_W'(py);
		prod_z_s1 <= PROD_W'(nz) * PROD_W'(pz);
		off_s1    <= ent.plane_offset;
		cf_s1     <= ent.child_front;
		cb_s1     <= ent.child_back;
		neg_s2    <= side[SIDE_W-1];
		cf_s2     <= cf_s1;
		cb_s2     <= cb_s1;
	end

	// exact: products and offset share the same fraction bits
	assign side = SIDE_W'(prod_x_s1) + SIDE_W'(prod_y_s1) + SIDE_W'(prod_z_s1)
		- SIDE_W'(off_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ent_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign res.vld         = vld_s2;
	assign res.neg         = neg_s2;
	assign res.child_front = cf_s2;
	assign res.child_back  = cb_s2;

endmodule

FILE: hdl/bspl_walk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspl_walk_ctrl
// Query sequencer: walks the tree from node 0, one table read per node,
// bounds the walk and holds the result in the output register.
// ----------------------------------------------------------------------------
module bspl_walk_ctrl #(
	parameter int NODE_COUNT = 4096,
	parameter int MEM_DEPTH  = 4096,
	parameter int MEM_AW     = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_vld,
	output logic                                  in_rdy,
	input  bspl_pkg::cmd_t                        in_cmd,
	input  bspl_pkg::point_t                      in_point,
	output logic                                  rd_en,
	output logic [MEM_AW-1:0]                     rd_addr,
	input  bspl_pkg::side_res_t                   res,
	output bspl_pkg::point_t                      point,
	output logic                                  out_vld,
	input  logic                                  out_rdy,
	output logic [bspl_pkg::NODE_IDX_W-1:0]       out_leaf,
	output logic                                  out_err
);
	import bspl_pkg::*;

	localparam int SW = $clog2(NODE_COUNT + 1);

	walk_state_t               state_q, state_d;
	logic signed [CHILD_W-1:0] node_q, node_d;
	logic [SW-1:0]             steps_q;
	point_t                    pt_q;
	logic [NODE_IDX_W-1:0]     leaf_q, fin_leaf;
	logic                      err_q, fin_err;
	logic                      start, steps_inc, fin_load, out_load;
	logic signed [CHILD_W-1:0] next_child;
	logic                      over;
	logic                      out_vld_q;
	logic [NODE_IDX_W-1:0]     out_leaf_q;
	logic                      out_err_q;

	assign next_child = res.neg ? res.child_back : res.child_front;
	assign over = (32'(next_child[CHILD_W-2:0]) >= 32'(NODE_COUNT))
		|| (32'(steps_q) >= 32'(NODE_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_rdy    = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = node_q[MEM_AW-1:0];
		node_d    = node_q;
		start     = 1'b0;
		steps_inc = 1'b0;
		fin_load  = 1'b0;
		fin_leaf  = '0;
		fin_err   = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (in_vld && in_cmd == CMD_QUERY) begin
					start   = 1'b1;
					node_d  = '0;
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				rd_en     = 1'b1;
				steps_inc = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (res.vld) begin
					if (next_child[CHILD_W-1]) begin
						// leaf reached: child holds its complement
						fin_load = 1'b1;
						fin_leaf = ~next_child[NODE_IDX_W-1:0];
						state_d  = ST_FIN;
					end else if (over) begin
						fin_load = 1'b1;
						fin_err  = 1'b1;
						state_d  = ST_FIN;
					end else begin
						rd_en     = 1'b1;
						rd_addr   = next_child[MEM_AW-1:0];
						node_d    = next_child;
						steps_inc = 1'b1;
					end
				end
			end
			ST_FIN: begin
				if (!out_vld_q || out_rdy) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q    <= '0;
			steps_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			node_q <= node_d;
			if (start) begin
				steps_q <= '0;
			end else if (steps_inc) begin
				steps_q <= steps_q + SW'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_rdy) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pt_q <= in_point;
		end
		if (fin_load) begin
			leaf_q <= fin_leaf;
			err_q  <= fin_err;
		end
		if (out_load) begin
			out_leaf_q <= leaf_q;
			out_err_q  <= err_q;
		end
	end

	assign point    = pt_q;
	assign out_vld  = out_vld_q;
	assign out_leaf = out_leaf_q;
	assign out_err  = out_err_q;

`ifndef NO_ASSERTIONS
	a_read_returns: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> ##3 res.vld)
		else $error("table read did not return a side result after three cycles");

	a_result_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		res.vld |-> state_q == ST_WAIT)
		else $error("side result arrived outside a walk");

	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(steps_q) <= 32'(NODE_COUNT))
		else $error("walk step count ran past the node count");

	a_read_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> 32'(rd_addr) < 32'(MEM_DEPTH))
		else $error("table read beyond the stored entries");
`endif

endmodule

FILE: tb/sv/tb_bsp_point_leaf_locator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bsp_point_leaf_locator
// Self-checking bench for the BSP point leaf locator. A directed block loads
// small trees and probes the field extremes, the zero side value and looping
// trees. A random block then mixes node writes, which keep the tree acyclic
// and fully loaded, with point queries. A tracker walks its own copy of the
// node table for each query and checks every result beat against it.
// ----------------------------------------------------------------------------
module tb_bsp_point_leaf_locator;
	import bspl_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1180;

	typedef struct {
		logic [NODE_IDX_W-1:0] leaf;
		logic                  err;
	} leaf_result_t;

	class leaf_tracker;
		node_entry_t  nodes[NODE_COUNT_DEF];
		leaf_result_t pending_leaves[$];
		int           mismatches;

		function new();
			mismatches = 0;
		endfunction

		task report(string what);
			$display("%0t ns mismatch: %s", $time, what);
			mismatches++;
		endtask

		function int outstanding();
			return pending_leaves.size();
		endfunction

		// Store a node entry, or walk the tree and queue the leaf it ends in.
		function void take_beat(cmd_t cmd, logic [S_TDATA_W-1:0] d);
			int           idx;
			int           node;
			int           steps;
			logic         err;
			longint       px;
			longint       py;
			longint       pz;
			longint       side;
			node_entry_t  e;
			leaf_result_t r;
			if (cmd == CMD_WRITE) begin
				idx = int'(d[S_IDX_LO +: NODE_IDX_W]);
				if (idx < NODE_COUNT_DEF) begin
					e.normal_x     = d[S_NX_LO +: NRM_W];
					e.normal_y     = d[S_NY_LO +: NRM_W];
					e.normal_z     = d[S_NZ_LO +: NRM_W];
					e.plane_offset = d[S_OFF_LO +: OFF_W];
					e.child_front  = d[S_CF_LO +: CHILD_W];
					e.child_back   = d[S_CB_LO +: CHILD_W];
					nodes[idx] = e;
				end
				return;
			end
			px = $signed(d[S_PX_LO +: PT_W]);
			py = $signed(d[S_PY_LO +: PT_W]);
			pz = $signed(d[S_PZ_LO +: PT_W]);
			node = 0;
			steps = 0;
			err = 1'b0;
			while (node >= 0 && !err) begin
				if (node >= NODE_COUNT_DEF || steps >= NODE_COUNT_DEF) begin
					err = 1'b1;
				end else begin
					steps++;
					e = nodes[node];
					side = longint'(e.normal_x) * px + longint'(e.normal_y) * py
						+ longint'(e.normal_z) * pz - longint'(e.plane_offset);
					node = (side < 0) ? int'(e.child_back) : int'(e.child_front);
				end
			end
			r.err = err;
			r.leaf = err ? '0 : NODE_IDX_W'(-1 - node);
			pending_leaves = {pending_leaves, r};
		endfunction

		task match_leaf(logic [M_TDATA_W-1:0] tdata, logic tuser);
			leaf_result_t r;
			if (pending_leaves.size() == 0) begin
				report($sformatf("result beat with no query waiting, leaf %0d error %0b",
					tdata[NODE_IDX_W-1:0], tuser));
				return;
			end
			r = pending_leaves.pop_front();
			if (tdata[NODE_IDX_W-1:0] !== r.leaf)
				report($sformatf("leaf_index got %0d expected %0d",
					tdata[NODE_IDX_W-1:0], r.leaf));
			if (tuser !== r.err)
				report($sformatf("walk_error got %0b expected %0b", tuser, r.err));
			if (tdata[M_TDATA_W-1:NODE_IDX_W] !== '0)
				report($sformatf("tdata fill bits got %h", tdata[M_TDATA_W-1:NODE_IDX_W]));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;

	leaf_tracker lt;
	bit          written[NODE_COUNT_DEF];
	int          written_list[$];
	bit          send_burst;
	bit          recv_burst;
	int          cyc;

	bsp_point_leaf_locator #(
		.NODE_COUNT(NODE_COUNT_DEF)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [S_TDATA_W-1:0] pack_beat(int idx, int nx, int ny, int nz,
			int off, int cf, int cb, int px, int py, int pz);
		logic [S_TDATA_W-1:0] d;
		d = '0;
		d[S_IDX_LO +: NODE_IDX_W] = idx[NODE_IDX_W-1:0];
		d[S_NX_LO +: NRM_W]       = nx[NRM_W-1:0];
		d[S_NY_LO +: NRM_W]       = ny[NRM_W-1:0];
		d[S_NZ_LO +: NRM_W]       = nz[NRM_W-1:0];
		d[S_OFF_LO +: OFF_W]      = off[OFF_W-1:0];
		d[S_CF_LO +: CHILD_W]     = cf[CHILD_W-1:0];
		d[S_CB_LO +: CHILD_W]     = cb[CHILD_W-1:0];
		d[S_PX_LO +: PT_W]        = px[PT_W-1:0];
		d[S_PY_LO +: PT_W]        = py[PT_W-1:0];
		d[S_PZ_LO +: PT_W]        = pz[PT_W-1:0];
		return d;
	endfunction

	task automatic send_beat(cmd_t cmd, logic [S_TDATA_W-1:0] d);
		int gap;
		if ($urandom_range(0, 29) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		lt.take_beat(cmd, d);
	endtask

	// Point fields of a write beat carry noise.
	task automatic put_node(int idx, int nx, int ny, int nz, int off, int cf, int cb);
		send_beat(CMD_WRITE, pack_beat(idx, nx, ny, nz, off, cf, cb,
			$urandom_range(0, 131071), $urandom_range(0, 131071), $urandom_range(0, 131071)));
		if (!written[idx]) begin
			written[idx] = 1'b1;
			written_list = {written_list, idx};
		end
	endtask

	// Node fields of a query beat carry noise.
	task automatic ask_point(int px, int py, int pz);
		send_beat(CMD_QUERY, pack_beat($urandom_range(0, 4095), $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, px, py, pz));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (lt.outstanding() != 0);
	endtask

	function automatic int rand_normal();
		case ($urandom_range(0, 9))
			0: return 16384;
			1: return -16384;
			2: return 0;
			default: return int'($urandom_range(0, 32768)) - 16384;
		endcase
	endfunction

	function automatic int rand_offset();
		case ($urandom_range(0, 5))
			0: return 1073741823;
			1: return -1073741824;
			2, 3: return int'($urandom_range(0, 131072)) - 65536;
			default: return int'($urandom_range(0, 32'h7FFF_FFFF)) - 1073741824;
		endcase
	endfunction

	function automatic int rand_coord();
		if ($urandom_range(0, 4) == 0)
			return int'($urandom_range(0, 128)) - 64;
		return int'($urandom_range(0, 131071)) - 65536;
	endfunction

	// Point only at loaded nodes of higher index, so every walk ends in a leaf
	// and never reads an entry that was not written.
	function automatic int pick_child(int idx);
		int c;
		int j;
		int k;
		bit found;
		c = -1 - int'($urandom_range(0, 4095));
		found = 1'b0;
		if ($urandom_range(0, 3) != 0) begin
			j = idx + int'($urandom_range(1, 8));
			if (j < NODE_COUNT_DEF && written[j]) begin
				c = j;
				found = 1'b1;
			end
			for (k = 0; k < 8 && !found; k++) begin
				j = written_list[$urandom_range(0, written_list.size() - 1)];
				if (j > idx) begin
					c = j;
					found = 1'b1;
				end
			end
		end
		return c;
	endfunction

	task automatic random_write();
		int idx;
		case ($urandom_range(0, 9))
			0: idx = 0;
			1, 2, 3, 4: idx = $urandom_range(1, 63);
			default: idx = $urandom_range(0, 4095);
		endcase
		put_node(idx, rand_normal(), rand_normal(), rand_normal(), rand_offset(),
			pick_child(idx), pick_child(idx));
	endtask

	initial begin
		int i;
		lt = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_WRITE;
		m_tready = 1'b0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// zero side value goes front; offset extremes at the deepest node
		put_node(4095, 16384, -16384, 0, 1073741823, -1, -4096);
		put_node(0, 0, 0, 0, 0, 4095, -6);
		ask_point(0, 0, 0);
		ask_point(65535, -65536, 0);
		put_node(4095, -16384, 16384, 16384, -1073741824, -4096, -1);
		ask_point(-65536, 65535, -65536);
		ask_point(65535, 65535, 65535);
		ask_point(-65536, -65536, -65536);
		// side value of minus one goes back
		put_node(0, 0, 0, 0, 1, 4095, -4096);
		ask_point(-65536, 65535, 0);
		// self loop, then a two node loop: overlong walks
		put_node(0, 16384, 0, 0, 0, 0, 0);
		ask_point(5, 5, 5);
		put_node(1, 0, 0, 0, 0, 0, 0);
		put_node(0, 0, 16384, 0, 0, 1, 1);
		ask_point(-5, 5, 0);
		// restore an acyclic root before the random part
		put_node(1, 16384, 0, 0, 0, -100, -4096);
		put_node(0, 0, 0, 16384, 0, 1, 4095);
		ask_point(0, 0, 5);
		ask_point(0, 0, -5);
		ask_point(-3, 0, 7);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				drain_results();
			if ($urandom_range(0, 99) < 55)
				random_write();
			else
				ask_point(rand_coord(), rand_coord(), rand_coord());
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (lt.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				recv_burst = !recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			lt.match_leaf(m_tdata, m_tuser);
		end
	end

	initial begin
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: bsp_point_leaf_locator.f
hdl/bspl_pkg.sv
hdl/bspl_node_mem.sv
hdl/bspl_side_eval.sv
hdl/bspl_walk_ctrl.sv
hdl/bsp_point_leaf_locator.sv
tb/sv/tb_bsp_point_leaf_locator.sv
